[rtl/mpdfa_pkg.sv]
// Shared types and constants of the multi-pattern DFA matcher.
// No dependencies; imported by the matcher top level.
package mpdfa_pkg;

  // Item selector carried on in_tuser
  typedef enum logic [2:0] {
    FUNC_LOAD_CLASS = 3'd0,
    FUNC_LOAD_TRANS = 3'd1,
    FUNC_LOAD_MATCH = 3'd2,
    FUNC_SCAN       = 3'd3,
    FUNC_NEW_TEXT   = 3'd4
  } func_t;

  localparam int BYTE_W   = 8;
  localparam int IDX_W    = 9;   // state_index / target_state port width
  localparam int CLS_W    = 6;   // class_index port width
  localparam int PID_W    = 8;
  localparam int POS_W    = 16;
  localparam int MENT_W   = PID_W + 1;  // match entry: valid flag over pattern id

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;

  // Result buffer: must cover all items in flight plus what waits for the sink
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int FIFO_CW    = 4;

  // Item as it travels down the pipeline
  typedef struct packed {
    func_t              func;
    logic               wr_ok;      // load passes its range checks
    logic               too_long;   // scan refused at the length limit
    logic               last;
    logic [POS_W-1:0]   offset;
    logic [IDX_W-1:0]   state_index;
    logic [CLS_W-1:0]   class_index;
    logic [IDX_W-1:0]   target_state;
    logic               match_valid;
    logic [PID_W-1:0]   match_id;
  } item_t;

  typedef struct packed {
    logic               too_long;
    logic               end_of_text;
    logic [POS_W-1:0]   end_offset;
    logic [PID_W-1:0]   pattern_id;
    logic               hit;
  } result_t;

endpackage

[rtl/mpdfa_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mpdfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/multi_pattern_dfa_matcher_core.sv]
// Multi-pattern DFA matcher: Aho-Corasick scan over software-loaded tables.
// Depends on mpdfa_pkg and mpdfa_ram.
//
// Usage:
//   in_*  : one item per transfer. in_tuser selects the function (load class
//           map, load transition, load match entry, scan byte, new text);
//           in_tdata holds the table and byte fields; in_tlast marks the last
//           byte of a text on scans.
//   out_* : one result per scan that enters a matching state, ends the text,
//           or is refused at the length limit; in_tlast comes back on out_tlast.
//   cfg_* : write of max_text_len, taken every cycle. The user writes it only
//           while idle; the block itself does not enforce it.
// Throughput: one item per cycle while in_tready is high. The loop that sets
//   it is the transition RAM: its registered read data is the next scan's
//   state, fed straight into the next read address.
// Reset: state at the root, position 0, max_text_len 65535. Table contents
//   are undefined until loaded; there is no clearing pass.
// Stall: up to eight results queue in an output buffer; in_tready falls
//   once queued results plus items in flight fill it, and rises again as
//   the sink takes results.
module multi_pattern_dfa_matcher_core
  import mpdfa_pkg::*;
#(
  parameter int NUM_STATES   = 512,
  parameter int NUM_CLASSES  = 64,
  parameter int NUM_PATTERNS = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: byte_value[7:0], state_index[16:8], class_index[22:17],
  //   target_state[31:23], match_valid[32], match_id[40:33], zero pad
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [2:0]            in_tuser,   // func
  input  logic                  in_tlast,   // last_of_text
  // out_tdata: hit[0], pattern_id[8:1], end_offset[24:9], too_long[25], zero pad
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,  // end_of_text
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [POS_W-1:0]      cfg_data    // max_text_len
);

  localparam int SW = $clog2(NUM_STATES);
  localparam int CW = $clog2(NUM_CLASSES);

  // ---------------- configuration
  logic [POS_W-1:0] max_len_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= '1;
    end else if (cfg_valid) begin
      max_len_r <= cfg_data;
    end
  end

  // ---------------- stage 0: accept, position, class map access
  logic             in_acc;
  item_t            it0;
  logic [BYTE_W-1:0] byte0;
  logic             class_ok, state_ok, id_ok;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             cls_we;
  logic [CW-1:0]    cls_rd;

  assign in_acc = in_tvalid && in_tready;
  assign byte0  = in_tdata[7:0];

  always_comb begin
    it0.func         = func_t'(in_tuser);
    it0.state_index  = in_tdata[16:8];
    it0.class_index  = in_tdata[22:17];
    it0.target_state = in_tdata[31:23];
    it0.match_valid  = in_tdata[32];
    it0.match_id     = in_tdata[40:33];
    it0.last         = in_tlast;

    class_ok = 32'(it0.class_index) < NUM_CLASSES;
    state_ok = 32'(it0.state_index) < NUM_STATES;
    id_ok    = 32'(it0.match_id) < NUM_PATTERNS;

    case (it0.func)
      FUNC_LOAD_CLASS: it0.wr_ok = class_ok;
      FUNC_LOAD_TRANS: it0.wr_ok = state_ok && class_ok;
      FUNC_LOAD_MATCH: it0.wr_ok = state_ok && id_ok;
      default:         it0.wr_ok = 1'b0;
    endcase

    it0.too_long = (it0.func == FUNC_SCAN) && (pos_r >= max_len_r);
    it0.offset   = it0.too_long ? pos_r : pos_r + POS_W'(1);

    pos_nxt = pos_r;
    if (in_acc) begin
      if (it0.func == FUNC_NEW_TEXT) begin
        pos_nxt = '0;
      end else if (it0.func == FUNC_SCAN && !it0.too_long) begin
        pos_nxt = it0.offset;
      end
    end
  end

  assign cls_we = in_acc && (it0.func == FUNC_LOAD_CLASS) && it0.wr_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  mpdfa_ram #(.WIDTH(CW), .DEPTH(256)) u_class_ram (
    .clk   (clk),
    .we    (cls_we),
    .waddr (byte0),
    .wdata (CW'(it0.class_index)),
    .raddr (byte0),
    .rdata (cls_rd)
  );

  // ---------------- pipeline registers
  logic  v1_r, v2_r, v3_r;
  item_t p1_r, p2_r, p3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_r <= it0;
    p2_r <= p1_r;
    p3_r <= p2_r;
  end

  // ---------------- stage 1: transition access
  logic [SW-1:0]    cur_r, cur_nxt;
  logic [SW-1:0]    trans_rd;
  logic             trans_we;
  logic [SW-1:0]    trans_wdata;
  logic             step2;

  // state after the item now in stage 2 has taken effect
  assign step2 = v2_r && (p2_r.func == FUNC_SCAN) && !p2_r.too_long;

  always_comb begin
    if (step2) begin
      cur_nxt = trans_rd;
    end else if (v2_r && p2_r.func == FUNC_NEW_TEXT) begin
      cur_nxt = '0;
    end else begin
      cur_nxt = cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
    end else begin
      cur_r <= cur_nxt;
    end
  end

  assign trans_we    = v1_r && (p1_r.func == FUNC_LOAD_TRANS) && p1_r.wr_ok;
  assign trans_wdata = (32'(p1_r.target_state) < NUM_STATES) ? SW'(p1_r.target_state) : '0;

  mpdfa_ram #(.WIDTH(SW), .DEPTH(NUM_STATES * (1 << CW))) u_trans_ram (
    .clk   (clk),
    .we    (trans_we),
    .waddr ({SW'(p1_r.state_index), CW'(p1_r.class_index)}),
    .wdata (trans_wdata),
    .raddr ({cur_nxt, cls_rd}),
    .rdata (trans_rd)
  );

  // ---------------- stage 2: match entry access
  logic              match_we;
  logic [MENT_W-1:0] match_rd;

  assign match_we = v2_r && (p2_r.func == FUNC_LOAD_MATCH) && p2_r.wr_ok;

  mpdfa_ram #(.WIDTH(MENT_W), .DEPTH(NUM_STATES)) u_match_ram (
    .clk   (clk),
    .we    (match_we),
    .waddr (SW'(p2_r.state_index)),
    .wdata ({p2_r.match_valid, p2_r.match_id}),
    .raddr (trans_rd),
    .rdata (match_rd)
  );

  // ---------------- stage 3: result build
  logic    push;
  result_t res3;

  always_comb begin
    res3.too_long    = p3_r.too_long;
    res3.end_of_text = p3_r.last;
    res3.end_offset  = p3_r.offset;
    res3.hit         = !p3_r.too_long && match_rd[MENT_W-1];
    res3.pattern_id  = res3.hit ? match_rd[PID_W-1:0] : '0;
    push = v3_r && (p3_r.func == FUNC_SCAN) && (p3_r.too_long || res3.hit || p3_r.last);
  end

  // ---------------- result buffer
  result_t              fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0]   cnt_r, cnt_nxt;
  logic [FIFO_CW-1:0]   occupancy;
  logic                 pop;
  result_t              res_out;

  assign pop       = out_tvalid && out_tready;
  assign occupancy = cnt_r + FIFO_CW'(v1_r) + FIFO_CW'(v2_r) + FIFO_CW'(v3_r);
  assign in_tready = occupancy < FIFO_CW'(FIFO_DEPTH);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + FIFO_CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= res3;
    end
  end

  assign res_out    = fifo_r[rd_ptr_r];
  assign out_tvalid = cnt_r != '0;
  assign out_tlast  = res_out.end_of_text;
  assign out_tdata  = {6'b0, res_out.too_long, res_out.end_offset,
                       res_out.pattern_id, res_out.hit};

  // ---------------- assertions
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && cnt_r == FIFO_CW'(FIFO_DEPTH)))
    else $error("result buffer overflow");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occupancy <= FIFO_CW'(FIFO_DEPTH))
    else $error("in-flight items exceed buffer space");

  a_refused_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_out.too_long |-> !res_out.hit && res_out.pattern_id == '0)
    else $error("refused byte reports a hit");

  a_new_text_pos: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && it0.func == FUNC_NEW_TEXT |=> pos_r == '0)
    else $error("position not cleared by new text");

endmodule

[bench/multi_pattern_dfa_matcher_core_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for multi_pattern_dfa_matcher_core: directed table, then random phases.
// Builds DFA tables over the streams and predicts scan reports in its own matcher copy.
// Depends on mpdfa_pkg and the matcher RTL only.
module multi_pattern_dfa_matcher_core_tb;
  import mpdfa_pkg::*;

  localparam int NUM_ST  = 512;
  localparam int NUM_CL  = 64;
  localparam int NUM_PAT = 256;

  localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

  localparam int RESULT_LAT  = 3;
  localparam int SETTLE_CYC  = 2 * RESULT_LAT;
  localparam int IDLE_PCT    = 32;
  localparam int N_PHASE     = 4;
  localparam int SCANS_PER_PHASE = 360;
  localparam int N_SET_ST    = 10;
  localparam int N_SET_CL    = 6;
  localparam logic [7:0] LOWER_A = 8'h61;
  localparam logic [7:0] LOWER_Z = 8'h7a;

  typedef struct packed {
    func_t             func;
    logic [7:0]        byte_value;
    logic [8:0]        state_index;
    logic [5:0]        class_index;
    logic [8:0]        target_state;
    logic              match_valid;
    logic [7:0]        match_id;
    logic              last_of_text;
  } text_item_t;

  typedef struct packed {
    logic              hit;
    logic [7:0]        pattern_id;
    logic [15:0]       end_offset;
    logic              end_of_text;
    logic              too_long;
  } report_t;

  typedef struct packed {
    logic              set_lim;   // drain and write max_text_len before this row
    logic [15:0]       lim;
    text_item_t        item;
    logic              typed;     // want holds the expected report
    report_t           want;
  } dir_row_t;

  localparam report_t NO_REP = '0;
  localparam int N_DIR = 26;

  // Tiny hand-built DFA: root -'a'/'A'-> 511 (id 255) -0xFF-> 1 (id 0) -0x00-> root
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{1'b0, 16'd0, '{FUNC_LOAD_CLASS, 8'h00, 9'd0, 6'd0, 9'd0, 1'b0, 8'h00, 1'b0}, 1'b0, NO_REP},
    '{1'b0, 16'd0, '{FUNC_LOAD_CLASS, 8'hFF, 9'd0, 6'd63, 9'd0, 1'b0, 8'h00, 1'b0}, 1'b0, NO_REP},
    '{1'b0, 16'd0, '{FUNC_LOAD_CLASS, 8'h41, 9'd0, 6'd5, 9'd0, 1'b0, 8'h00, 1'b0}, 1'b0, NO_REP},
    '{1'b0, 16'd0, '{FUNC_LOAD_CLASS, 8'h61, 9'd0, 6'd5, 9'd0, 1'b0, 8'h00, 1'b0}, 1'b0, NO_REP},
    '{1'b0, 16'd0, '{FUNC_LOAD_TRANS, 8'h00, 9'd0, 6'd5, 9'd511, 1'b0, 8'h00, 1'b0}, 1'b0, NO_REP},
    '{1'b0, 16'd0, '{FUNC_LOAD_TRANS, 8'h00, 9'd511, 6'd63, 9'd1, 1'b0, 8'h00, 1'b0}, 1'b0, NO_REP},
    '{1'b0, 16'd0, '{FUNC_LOAD_TRANS, 8'h00, 9'd1, 6'd0, 9'd0, 1'b0, 8'h00, 1'b0}, 1'b0, NO_REP},
    '{1'b0, 16'd0, '{FUNC_LOAD_TRANS, 8'h00, 9'd0, 6'd0, 9'd0, 1'b0, 8'h00, 1'b0}, 1'b0, NO_REP},
    '{1'b0, 16'd0, '{FUNC_LOAD_MATCH, 8'h00, 9'd511, 6'd0, 9'd0, 1'b1, 8'hFF, 1'b0}, 1'b0, NO_REP},
    '{1'b0, 16'd0, '{FUNC_LOAD_MATCH, 8'h00, 9'd1, 6'd0, 9'd0, 1'b1, 8'h00, 1'b0}, 1'b0, NO_REP},
    '{1'b0, 16'd0, '{FUNC_LOAD_MATCH, 8'h00, 9'd0, 6'd0, 9'd0, 1'b0, 8'hAA, 1'b0}, 1'b0, NO_REP},
    '{1'b0, 16'd0, '{func_t'(FUNC_SPARE_LO), 8'hFF, 9'd511, 6'd63, 9'd511, 1'b1, 8'hFF, 1'b1},
      1'b0, NO_REP},
    '{1'b0, 16'd0, '{func_t'(FUNC_SPARE_HI), 8'h00, 9'd0, 6'd0, 9'd0, 1'b0, 8'h00, 1'b0},
      1'b0, NO_REP},
    '{1'b0, 16'd0, '{FUNC_SCAN, 8'h41, 9'd0, 6'd0, 9'd0, 1'b0, 8'h00, 1'b0},
      1'b1, '{1'b1, 8'hFF, 16'd1, 1'b0, 1'b0}},
    '{1'b0, 16'd0, '{FUNC_SCAN, 8'hFF, 9'd0, 6'd0, 9'd0, 1'b0, 8'h00, 1'b0},
      1'b1, '{1'b1, 8'h00, 16'd2, 1'b0, 1'b0}},
    // end of text without a hit: pattern id must read zero
    '{1'b0, 16'd0, '{FUNC_SCAN, 8'h00, 9'd0, 6'd0, 9'd0, 1'b0, 8'h00, 1'b1},
      1'b1, '{1'b0, 8'h00, 16'd3, 1'b1, 1'b0}},
    // scanning goes on past the last byte until a new text
    '{1'b0, 16'd0, '{FUNC_SCAN, 8'h61, 9'd0, 6'd0, 9'd0, 1'b0, 8'h00, 1'b0},
      1'b1, '{1'b1, 8'hFF, 16'd4, 1'b0, 1'b0}},
    '{1'b0, 16'd0, '{FUNC_NEW_TEXT, 8'h00, 9'd0, 6'd0, 9'd0, 1'b0, 8'h00, 1'b0}, 1'b0, NO_REP},
    '{1'b0, 16'd0, '{FUNC_SCAN, 8'h00, 9'd0, 6'd0, 9'd0, 1'b0, 8'h00, 1'b0}, 1'b0, NO_REP},
    '{1'b0, 16'd0, '{FUNC_SCAN, 8'h61, 9'd0, 6'd0, 9'd0, 1'b0, 8'h00, 1'b1},
      1'b1, '{1'b1, 8'hFF, 16'd2, 1'b1, 1'b0}},
    '{1'b1, 16'd1, '{FUNC_NEW_TEXT, 8'h00, 9'd0, 6'd0, 9'd0, 1'b0, 8'h00, 1'b0}, 1'b0, NO_REP},
    '{1'b0, 16'd0, '{FUNC_SCAN, 8'h41, 9'd0, 6'd0, 9'd0, 1'b0, 8'h00, 1'b0},
      1'b1, '{1'b1, 8'hFF, 16'd1, 1'b0, 1'b0}},
    '{1'b0, 16'd0, '{FUNC_SCAN, 8'hFF, 9'd0, 6'd0, 9'd0, 1'b0, 8'h00, 1'b1},
      1'b1, '{1'b0, 8'h00, 16'd1, 1'b1, 1'b1}},
    // limit of zero refuses everything
    '{1'b1, 16'd0, '{FUNC_SCAN, 8'hFF, 9'd0, 6'd0, 9'd0, 1'b0, 8'h00, 1'b0},
      1'b1, '{1'b0, 8'h00, 16'd1, 1'b0, 1'b1}},
    '{1'b0, 16'd0, '{FUNC_NEW_TEXT, 8'h00, 9'd0, 6'd0, 9'd0, 1'b0, 8'h00, 1'b0}, 1'b0, NO_REP},
    '{1'b0, 16'd0, '{FUNC_SCAN, 8'h00, 9'd0, 6'd0, 9'd0, 1'b0, 8'h00, 1'b1},
      1'b1, '{1'b0, 8'h00, 16'd0, 1'b1, 1'b1}}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [2:0]            in_tuser = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [POS_W-1:0]      cfg_data = '0;

  // Matcher copy kept by the bench
  logic [5:0]  class_of [256];
  logic [8:0]  next_of  [NUM_ST*NUM_CL];
  logic [8:0]  entry_of [NUM_ST];
  bit          class_set [256];
  bit          next_set  [NUM_ST*NUM_CL];
  bit          entry_set [NUM_ST];
  logic [8:0]  dfa_state = '0;
  logic [15:0] text_pos = '0;
  logic [15:0] len_limit = 16'hFFFF;

  report_t awaited_reports [$];
  bit      steady = 1'b0;
  int      bad_count = 0;
  int      items_sent = 0;
  int      scans_sent = 0;
  int      reports_checked = 0;
  int      hits_seen = 0;
  int      refused_seen = 0;
  int      limits_used = 0;

  multi_pattern_dfa_matcher_core #(
    .NUM_STATES  (NUM_ST),
    .NUM_CLASSES (NUM_CL),
    .NUM_PATTERNS(NUM_PAT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Fields are as wide as the tables, so the range checks of the loads always pass.
  function automatic bit advance_matcher(input text_item_t it, output report_t rep);
    logic [8:0] ent;
    rep = '0;
    case (it.func)
      FUNC_LOAD_CLASS: begin
        class_of[it.byte_value] = it.class_index;
        class_set[it.byte_value] = 1'b1;
      end
      FUNC_LOAD_TRANS: begin
        next_of[{it.state_index, it.class_index}] = it.target_state;
        next_set[{it.state_index, it.class_index}] = 1'b1;
      end
      FUNC_LOAD_MATCH: begin
        entry_of[it.state_index] = {it.match_valid, it.match_id};
        entry_set[it.state_index] = 1'b1;
      end
      FUNC_SCAN: begin
        if (text_pos >= len_limit) begin
          rep = '{1'b0, 8'h00, text_pos, it.last_of_text, 1'b1};
          return 1'b1;
        end
        dfa_state = next_of[{dfa_state, class_of[it.byte_value]}];
        text_pos = text_pos + 16'd1;
        ent = entry_of[dfa_state];
        if (!ent[8] && !it.last_of_text) return 1'b0;
        rep = '{ent[8], ent[8] ? ent[7:0] : 8'h00, text_pos, it.last_of_text, 1'b0};
        return 1'b1;
      end
      FUNC_NEW_TEXT: begin
        dfa_state = '0;
        text_pos = '0;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // A byte may be scanned only if every table entry it reads has been loaded.
  function automatic bit byte_legal(input logic [7:0] b);
    logic [14:0] idx;
    if (!class_set[b]) return 1'b0;
    idx = {dfa_state, class_of[b]};
    if (!next_set[idx]) return 1'b0;
    return entry_set[next_of[idx]];
  endfunction

  function automatic bit pick_byte(output logic [7:0] b);
    logic [7:0] start;
    for (int t = 0; t < 8; t++) begin
      b = 8'($urandom_range(255));
      if (byte_legal(b)) return 1'b1;
    end
    start = 8'($urandom_range(255));
    for (int t = 0; t < 256; t++) begin
      b = start + 8'(t);
      if (byte_legal(b)) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic text_item_t random_item();
    text_item_t t;
    t.func         = func_t'(3'($urandom_range(7)));
    t.byte_value   = 8'($urandom_range(255));
    t.state_index  = 9'($urandom_range(NUM_ST-1));
    t.class_index  = 6'($urandom_range(NUM_CL-1));
    t.target_state = 9'($urandom_range(NUM_ST-1));
    t.match_valid  = 1'($urandom_range(1));
    t.match_id     = 8'($urandom_range(NUM_PAT-1));
    t.last_of_text = 1'($urandom_range(1));
    return t;
  endfunction

  task automatic note_mismatch(input string msg);
    bad_count++;
    $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want, input logic [15:0] offset);
    if (got !== want)
      note_mismatch($sformatf("%s got %0h want %0h (expected offset %0d)",
                              name, got, want, offset));
  endtask

  // Returns right after the accepting edge; the next call moves valid/data at the falling edge.
  task automatic push_item(input text_item_t it, input bit typed, input report_t want);
    report_t rep;
    bit      has_rep;
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.func;
    in_tlast  <= it.last_of_text;
    in_tdata  <= {7'd0, it.match_id, it.match_valid, it.target_state, it.class_index,
                  it.state_index, it.byte_value};
    do @(posedge clk); while (!in_tready);
    has_rep = advance_matcher(it, rep);
    if (typed) awaited_reports.push_back(want);
    else if (has_rep) awaited_reports.push_back(rep);
    items_sent++;
    if (it.func == FUNC_SCAN) scans_sent++;
  endtask

  // Sender holds off until every expected report is out and the pipe has settled.
  task automatic drain_outputs();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (awaited_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    len_limit = v;
    limits_used++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[0], out_tdata[8:1], out_tdata[24:9], out_tlast, out_tdata[25]};
      if (awaited_reports.size() == 0) begin
        note_mismatch($sformatf("report with nothing pending, offset %0d", got.end_offset));
      end else begin
        want = awaited_reports.pop_front();
        check_field("hit", 16'(got.hit), 16'(want.hit), want.end_offset);
        check_field("pattern_id", 16'(got.pattern_id), 16'(want.pattern_id), want.end_offset);
        check_field("end_offset", got.end_offset, want.end_offset, want.end_offset);
        check_field("end_of_text", 16'(got.end_of_text), 16'(want.end_of_text),
                    want.end_offset);
        check_field("too_long", 16'(got.too_long), 16'(want.too_long), want.end_offset);
        reports_checked++;
        if (got.hit) hits_seen++;
        if (got.too_long) refused_seen++;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [5:0]  cls_pick [N_SET_CL];
    logic [8:0]  st_pick  [N_SET_ST];
    logic [5:0]  fold [256];
    logic [15:0] lim;
    logic [7:0]  b;
    text_item_t  it;
    bit          ok;
    bit          paused;
    int          scans_done;
    int          txt_len;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < N_DIR; r++) begin
      if (DIR_ROWS[r].set_lim) begin
        drain_outputs();
        write_limit(DIR_ROWS[r].lim);
      end
      push_item(DIR_ROWS[r].item, DIR_ROWS[r].typed, DIR_ROWS[r].want);
    end

    for (int k = 0; k < N_SET_CL; k++) cls_pick[k] = 6'($urandom_range(NUM_CL-1));

    for (int phase = 0; phase < N_PHASE; phase++) begin
      case (phase)
        0:       lim = 16'hFFFF;
        1:       lim = 16'($urandom_range(5, 20));
        2:       lim = 16'($urandom_range(21, 65534));
        default: lim = 16'($urandom_range(2, 8));
      endcase
      drain_outputs();
      write_limit(lim);
      steady = (phase == 2);

      // Class map with case folding: upper and lower case letters share a class
      if (phase == 0) begin
        for (int i = 0; i < 256; i++) fold[i] = cls_pick[$urandom_range(N_SET_CL-1)];
        for (int i = LOWER_A; i <= LOWER_Z; i++) fold[i - 32] = fold[i];
        for (int i = 0; i < 256; i++) begin
          it = random_item();
          it.func = FUNC_LOAD_CLASS;
          it.byte_value = 8'(i);
          it.class_index = fold[i];
          push_item(it, 1'b0, NO_REP);
        end
      end else begin
        for (int i = 0; i < 24; i++) begin
          it = random_item();
          it.func = FUNC_LOAD_CLASS;
          it.class_index = cls_pick[$urandom_range(N_SET_CL-1)];
          push_item(it, 1'b0, NO_REP);
          if ((it.byte_value | 8'h20) >= LOWER_A && (it.byte_value | 8'h20) <= LOWER_Z) begin
            it.byte_value = it.byte_value ^ 8'h20;
            push_item(it, 1'b0, NO_REP);
          end
        end
      end

      st_pick[0] = '0;
      for (int s = 1; s < N_SET_ST; s++) st_pick[s] = 9'($urandom_range(1, NUM_ST-1));
      if (phase == 0) st_pick[N_SET_ST-1] = 9'(NUM_ST-1);
      for (int s = 0; s < N_SET_ST; s++) begin
        for (int c = 0; c < N_SET_CL; c++) begin
          it = random_item();
          it.func = FUNC_LOAD_TRANS;
          it.state_index = st_pick[s];
          it.class_index = cls_pick[c];
          it.target_state = st_pick[$urandom_range(N_SET_ST-1)];
          push_item(it, 1'b0, NO_REP);
        end
      end
      for (int s = 0; s < N_SET_ST; s++) begin
        it = random_item();
        it.func = FUNC_LOAD_MATCH;
        it.state_index = st_pick[s];
        it.match_valid = ($urandom_range(99) < 35);
        push_item(it, 1'b0, NO_REP);
      end

      scans_done = 0;
      paused = 1'b0;
      while (scans_done < SCANS_PER_PHASE) begin
        if (phase == 1 && !paused && scans_done >= SCANS_PER_PHASE / 2) begin
          drain_outputs();
          paused = 1'b1;
        end
        if ($urandom_range(99) < 3) begin
          // stray item: random load, new text or spare selector, never a blind scan
          it = random_item();
          if (it.func == FUNC_SCAN) it.func = func_t'(FUNC_SPARE_HI);
          push_item(it, 1'b0, NO_REP);
        end else begin
          if ($urandom_range(9) != 0) begin
            it = random_item();
            it.func = FUNC_NEW_TEXT;
            push_item(it, 1'b0, NO_REP);
          end
          txt_len = $urandom_range(1, 24);
          if (len_limit <= 30 && $urandom_range(4) < 2)
            txt_len = int'(len_limit) + $urandom_range(0, 3);
          for (int k = 0; k < txt_len; k++) begin
            ok = pick_byte(b);
            if (!ok) break;
            it = random_item();
            it.func = FUNC_SCAN;
            it.byte_value = b;
            it.last_of_text = (k == txt_len - 1);
            push_item(it, 1'b0, NO_REP);
            scans_done++;
          end
        end
      end
    end

    steady = 1'b0;
    drain_outputs();

    $display("Run covered %0d items (%0d byte scans) under %0d length limit settings.",
             items_sent, scans_sent, limits_used);
    $display("%0d reports compared: %0d pattern hits, %0d bytes refused as too long.",
             reports_checked, hits_seen, refused_seen);
    if (bad_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[multi_pattern_dfa_matcher_core.f]
rtl/mpdfa_pkg.sv
rtl/mpdfa_ram.sv
rtl/multi_pattern_dfa_matcher_core.sv
bench/multi_pattern_dfa_matcher_core_tb.sv
